/* design/obb_sat_pkg.sv */
// Shared constants and types for the oriented-rectangle separating-axis test.
`default_nettype none

package obb_sat_pkg;

  localparam int unsigned NumAxes  = 4;
  localparam int unsigned InW      = 288;
  localparam int unsigned OutW     = 72;
  localparam int unsigned Latency  = 13;

  localparam logic [15:0] QuarterTurn = 16'd16384;
  localparam logic [14:0] OneQ14      = 15'd16384;
  localparam logic [14:0] SinC1       = 15'd25736;
  localparam logic [13:0] SinC3       = 14'd10512;
  localparam logic [10:0] SinC5       = 11'd1160;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } axis_t;

  typedef struct packed {
    logic signed [31:0] acx;
    logic signed [31:0] acy;
    logic        [30:0] ahw;
    logic        [30:0] ahh;
    logic signed [31:0] bcx;
    logic signed [31:0] bcy;
    logic        [30:0] bhw;
    logic        [30:0] bhh;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } geo_t;

endpackage

`default_nettype wire

/* design/obb_separating_axis_collision.sv */
// Pipelined separating-axis overlap test for two oriented rectangles.
// Takes one rectangle pair per cycle and returns one result per pair; the
// pipeline stalls as a whole when the output beat is not taken. Stages 1-5
// evaluate four sine/cosine polynomials, 6-10 project both rectangles onto the
// four axes, 11-13 test overlap and pick the smallest overlap.
`default_nettype none

module obb_separating_axis_collision import obb_sat_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  // a_center_x, a_center_y, a_half_w, a_half_h, a_angle,
  // b_center_x, b_center_y, b_half_w, b_half_h, b_angle, zero pad
  input  wire logic [InW-1:0]  in_tdata,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  // hit, normal_x, normal_y, depth, zero pad
  output logic [OutW-1:0]      out_tdata
);

  logic en;
  logic [Latency-1:0] vld_r;

  assign en         = !vld_r[Latency-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[Latency-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Latency-2:0], in_tvalid};
    end
  end

  // input fields
  logic [15:0] a_ang, b_ang;
  geo_t        geo_nxt;
  assign a_ang = in_tdata[141:126];
  assign b_ang = in_tdata[283:268];

  always_comb begin
    geo_nxt.acx = in_tdata[31:0];
    geo_nxt.acy = in_tdata[63:32];
    geo_nxt.ahw = in_tdata[94:64];
    geo_nxt.ahh = in_tdata[125:95];
    geo_nxt.bcx = in_tdata[173:142];
    geo_nxt.bcy = in_tdata[205:174];
    geo_nxt.bhw = in_tdata[236:206];
    geo_nxt.bhh = in_tdata[267:237];
    geo_nxt.dx  = 33'(geo_nxt.bcx) - 33'(geo_nxt.acx);
    geo_nxt.dy  = 33'(geo_nxt.bcy) - 33'(geo_nxt.acy);
  end

  geo_t geo_r [7];

  // sine units: 0 A sin, 1 A cos, 2 B sin, 3 B cos
  logic        [14:0] z1_nxt [4];
  logic               n1_nxt [4];
  logic        [14:0] z1_r [4], z2_r [4], z3_r [4], z4_r [4];
  logic               n1_r [4], n2_r [4], n3_r [4], n4_r [4];
  logic        [28:0] sq2_r [4], sq3_r [4];
  logic        [13:0] t3_r [4];
  logic        [14:0] u4_r [4];
  logic signed [15:0] sv5_r [4];
  logic        [13:0] t3_nxt [4];
  logic        [14:0] u4_nxt [4];
  logic signed [15:0] sv5_nxt [4];

  always_comb begin
    logic [15:0] ang;
    logic [39:0] pr1;
    logic [42:0] pr2;
    logic [29:0] pr3;
    logic [14:0] p;
    logic [15:0] v;
    logic [14:0] vc;
    for (int k = 0; k < 4; k++) begin
      ang = (k < 2) ? a_ang : b_ang;
      if (k % 2 == 1) ang = ang + QuarterTurn;
      z1_nxt[k] = ang[14] ? 15'(QuarterTurn - {2'b00, ang[13:0]}) : {1'b0, ang[13:0]};
      n1_nxt[k] = ang[15];
      pr1 = 40'(sq2_r[k]) * 40'(SinC5);
      t3_nxt[k] = SinC3 - 14'(pr1[39:28]);
      pr2 = 43'(sq3_r[k]) * 43'(t3_r[k]);
      u4_nxt[k] = pr2[42:28];
      p = SinC1 - u4_r[k];
      pr3 = 30'(z4_r[k]) * 30'(p);
      v = pr3[29:14];
      vc = (v > 16'(OneQ14)) ? OneQ14 : v[14:0];
      sv5_nxt[k] = n4_r[k] ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
    end
  end

  // axes and projection terms
  axis_t ax_nxt [4];
  axis_t axp_r [7][4];
  logic signed [15:0] rc [2], rs [2];

  always_comb begin
    rs[0] = sv5_r[0]; rc[0] = sv5_r[1];
    rs[1] = sv5_r[2]; rc[1] = sv5_r[3];
    ax_nxt[0].x = rc[0];  ax_nxt[0].y = rs[0];
    ax_nxt[1].x = -rs[0]; ax_nxt[1].y = rc[0];
    ax_nxt[2].x = rc[1];  ax_nxt[2].y = rs[1];
    ax_nxt[3].x = -rs[1]; ax_nxt[3].y = rc[1];
  end

  logic signed [47:0] pcx6_r [4][2], pcy6_r [4][2];
  logic signed [31:0] m16_r [4][2], m26_r [4][2], m36_r [4][2], m46_r [4][2];
  logic signed [48:0] dxm6_r [4], dym6_r [4];
  logic signed [63:0] cen7_r [4][2], cen8_r [4][2], cen9_r [4][2];
  logic        [30:0] k17_r [4][2], k27_r [4][2];
  logic        [61:0] e18_r [4][2], e28_r [4][2];
  logic        [62:0] ext9_r [4][2];
  logic signed [63:0] lo10_r [4][2], hi10_r [4][2];
  logic        [62:0] ov11_r [4];
  logic               ok11_r [4];
  logic        [3:0]  flp_r [6];
  logic        [62:0] bov12_r [2];
  logic        [1:0]  bix12_r [2];
  logic               ok12_r;

  logic signed [63:0] cen7_nxt [4][2];
  logic        [30:0] k17_nxt [4][2], k27_nxt [4][2];
  logic        [3:0]  flp7_nxt;
  logic signed [63:0] lo10_nxt [4][2], hi10_nxt [4][2];
  logic        [62:0] ov11_nxt [4];
  logic               ok11_nxt [4];

  always_comb begin
    logic signed [31:0] k1, k2;
    logic signed [49:0] dot;
    logic signed [63:0] top, bot;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        cen7_nxt[i][j] = (64'(pcx6_r[i][j]) + 64'(pcy6_r[i][j])) <<< 14;
        k1 = m16_r[i][j] + m26_r[i][j];
        k2 = m36_r[i][j] - m46_r[i][j];
        k17_nxt[i][j] = (k1 < 0) ? 31'(-k1) : 31'(k1);
        k27_nxt[i][j] = (k2 < 0) ? 31'(-k2) : 31'(k2);
        lo10_nxt[i][j] = cen9_r[i][j] - $signed({1'b0, ext9_r[i][j]});
        hi10_nxt[i][j] = cen9_r[i][j] + $signed({1'b0, ext9_r[i][j]});
      end
      dot = 50'(dxm6_r[i]) + 50'(dym6_r[i]);
      flp7_nxt[i] = dot > 0;
      ok11_nxt[i] = (lo10_r[i][0] <= hi10_r[i][1]) && (lo10_r[i][1] <= hi10_r[i][0]);
      top = (hi10_r[i][0] < hi10_r[i][1]) ? hi10_r[i][0] : hi10_r[i][1];
      bot = (lo10_r[i][0] > lo10_r[i][1]) ? lo10_r[i][0] : lo10_r[i][1];
      ov11_nxt[i] = 63'(top - bot);
    end
  end

  // final pick
  logic        sel13;
  logic [62:0] best13;
  logic [1:0]  idx13;
  axis_t       nrm13;
  logic        hit_r;
  logic signed [15:0] nx_r, ny_r;
  logic [31:0] dep_r;

  assign sel13  = bov12_r[1] < bov12_r[0];
  assign best13 = sel13 ? bov12_r[1] : bov12_r[0];
  assign idx13  = sel13 ? bix12_r[1] : bix12_r[0];
  assign nrm13  = axp_r[6][idx13];

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[0] <= geo_nxt;
      for (int s = 1; s < 7; s++) geo_r[s] <= geo_r[s-1];
      for (int k = 0; k < 4; k++) begin
        z1_r[k]  <= z1_nxt[k];
        n1_r[k]  <= n1_nxt[k];
        z2_r[k]  <= z1_r[k];
        n2_r[k]  <= n1_r[k];
        sq2_r[k] <= 29'(30'(z1_r[k]) * 30'(z1_r[k]));
        z3_r[k]  <= z2_r[k];
        n3_r[k]  <= n2_r[k];
        sq3_r[k] <= sq2_r[k];
        t3_r[k]  <= t3_nxt[k];
        z4_r[k]  <= z3_r[k];
        n4_r[k]  <= n3_r[k];
        u4_r[k]  <= u4_nxt[k];
        sv5_r[k] <= sv5_nxt[k];
      end
      axp_r[0] <= ax_nxt;
      for (int s = 1; s < 7; s++) axp_r[s] <= axp_r[s-1];
      flp_r[0] <= flp7_nxt;
      for (int s = 1; s < 6; s++) flp_r[s] <= flp_r[s-1];
      for (int i = 0; i < 4; i++) begin
        dxm6_r[i] <= ax_nxt[i].x * geo_r[4].dx;
        dym6_r[i] <= ax_nxt[i].y * geo_r[4].dy;
        pcx6_r[i][0] <= ax_nxt[i].x * geo_r[4].acx;
        pcy6_r[i][0] <= ax_nxt[i].y * geo_r[4].acy;
        pcx6_r[i][1] <= ax_nxt[i].x * geo_r[4].bcx;
        pcy6_r[i][1] <= ax_nxt[i].y * geo_r[4].bcy;
        for (int j = 0; j < 2; j++) begin
          m16_r[i][j] <= ax_nxt[i].x * rc[j];
          m26_r[i][j] <= ax_nxt[i].y * rs[j];
          m36_r[i][j] <= ax_nxt[i].y * rc[j];
          m46_r[i][j] <= ax_nxt[i].x * rs[j];
          cen7_r[i][j] <= cen7_nxt[i][j];
          k17_r[i][j]  <= k17_nxt[i][j];
          k27_r[i][j]  <= k27_nxt[i][j];
          cen8_r[i][j] <= cen7_r[i][j];
          cen9_r[i][j] <= cen8_r[i][j];
          ext9_r[i][j] <= 63'(e18_r[i][j]) + 63'(e28_r[i][j]);
          lo10_r[i][j] <= lo10_nxt[i][j];
          hi10_r[i][j] <= hi10_nxt[i][j];
        end
        e18_r[i][0] <= 62'(geo_r[6].ahw) * 62'(k17_r[i][0]);
        e28_r[i][0] <= 62'(geo_r[6].ahh) * 62'(k27_r[i][0]);
        e18_r[i][1] <= 62'(geo_r[6].bhw) * 62'(k17_r[i][1]);
        e28_r[i][1] <= 62'(geo_r[6].bhh) * 62'(k27_r[i][1]);
        ov11_r[i] <= ov11_nxt[i];
        ok11_r[i] <= ok11_nxt[i];
      end
      // pairwise reduce; the earlier axis keeps a tie
      for (int p = 0; p < 2; p++) begin
        if (ov11_r[2*p+1] < ov11_r[2*p]) begin
          bov12_r[p] <= ov11_r[2*p+1];
          bix12_r[p] <= 2'(2*p+1);
        end else begin
          bov12_r[p] <= ov11_r[2*p];
          bix12_r[p] <= 2'(2*p);
        end
      end
      ok12_r <= ok11_r[0] && ok11_r[1] && ok11_r[2] && ok11_r[3];
      hit_r <= ok12_r;
      if (!ok12_r) begin
        nx_r  <= '0;
        ny_r  <= '0;
        dep_r <= '0;
      end else begin
        nx_r  <= flp_r[5][idx13] ? -nrm13.x : nrm13.x;
        ny_r  <= flp_r[5][idx13] ? -nrm13.y : nrm13.y;
        dep_r <= (|best13[62:60]) ? 32'hFFFF_FFFF : best13[59:28];
      end
    end
  end

  assign out_tdata = {7'd0, dep_r, ny_r, nx_r, hit_r};

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !hit_r |-> nx_r == 16'sd0 && ny_r == 16'sd0 && dep_r == 32'd0)
    else $error("miss result carries a nonzero normal or depth");

  a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hit_r |-> nx_r != 16'sd0 || ny_r != 16'sd0)
    else $error("hit result with zero normal");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> nx_r >= -16'sd16384 && nx_r <= 16'sd16384
                && ny_r >= -16'sd16384 && ny_r <= 16'sd16384)
    else $error("normal component out of Q1.14 range");

endmodule

`default_nettype wire

/* tb/sv/obb_separating_axis_collision_tb.sv */
// Testbench for the oriented-rectangle separating-axis collision pipeline.
`timescale 1ns / 1ps

module obb_separating_axis_collision_tb;
  import obb_sat_pkg::*;

  typedef struct {
    logic [31:0] acx, acy;
    logic [30:0] ahw, ahh;
    logic [15:0] aang;
    logic [31:0] bcx, bcy;
    logic [30:0] bhw, bhh;
    logic [15:0] bang;
  } pair_t;

  typedef struct {
    logic        hit;
    logic [15:0] nx, ny;
    logic [31:0] depth;
  } contact_t;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [InW-1:0]  in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [OutW-1:0] out_tdata;

  contact_t expected_contacts[$];
  int       n_errors;
  bit       stall_free;

  obb_separating_axis_collision i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("obb_separating_axis_collision verification failed");
    $finish;
  end

  function automatic longint poly_sine(longint z);
    longint z2, t, v;
    z2 = z * z;
    t  = (z2 * 1160) >>> 28;
    t  = 10512 - t;
    t  = (z2 * t) >>> 28;
    v  = (z * (25736 - t)) >>> 14;
    if (v > 16384) v = 16384;
    return v;
  endfunction

  function automatic longint sin_q14(logic [15:0] ang);
    logic [1:0] q;
    longint     r, v;
    q = ang[15:14];
    r = ang[13:0];
    if (q[0]) r = 16384 - r;
    v = poly_sine(r);
    return q[1] ? -v : v;
  endfunction

  // Projection interval onto (ux, uy) in Q28; 128-bit to stay exact.
  function automatic void project_rect(input longint cx, cy, hw, hh, c, s, ux, uy,
                                       output logic signed [127:0] lo, hi);
    logic signed [127:0] ctr, e1, e2;
    longint k1, k2;
    ctr = (128'(signed'(ux)) * cx + 128'(signed'(uy)) * cy) * 16384;
    k1 = ux * c + uy * s;
    k2 = uy * c - ux * s;
    if (k1 < 0) k1 = -k1;
    if (k2 < 0) k2 = -k2;
    e1 = 128'(signed'(hw)) * k1;
    e2 = 128'(signed'(hh)) * k2;
    lo = ctr - e1 - e2;
    hi = ctr + e1 + e2;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t res;
    longint as, ac, bs, bc, acx, acy, bcx, bcy, nx, ny, dot;
    longint ux[4], uy[4];
    logic signed [127:0] alo, ahi, blo, bhi, top, bot, ov, best;
    logic [127:0] dep;
    as = sin_q14(p.aang);
    ac = sin_q14(p.aang + 16'd16384);
    bs = sin_q14(p.bang);
    bc = sin_q14(p.bang + 16'd16384);
    acx = longint'(signed'(p.acx)); acy = longint'(signed'(p.acy));
    bcx = longint'(signed'(p.bcx)); bcy = longint'(signed'(p.bcy));
    ux[0] = ac;  uy[0] = as;
    ux[1] = -as; uy[1] = ac;
    ux[2] = bc;  uy[2] = bs;
    ux[3] = -bs; uy[3] = bc;
    res = '{1'b0, 16'd0, 16'd0, 32'd0};
    best = 0; nx = 0; ny = 0;
    for (int i = 0; i < 4; i++) begin
      project_rect(acx, acy, p.ahw, p.ahh, ac, as, ux[i], uy[i], alo, ahi);
      project_rect(bcx, bcy, p.bhw, p.bhh, bc, bs, ux[i], uy[i], blo, bhi);
      if (!(alo <= bhi && blo <= ahi)) return res;
      top = (ahi < bhi) ? ahi : bhi;
      bot = (alo > blo) ? alo : blo;
      ov = top - bot;
      if (i == 0 || ov < best) begin
        best = ov; nx = ux[i]; ny = uy[i];
      end
    end
    dot = (bcx - acx) * nx + (bcy - acy) * ny;
    if (dot > 0) begin
      nx = -nx; ny = -ny;
    end
    dep = best >>> 28;
    res.hit = 1'b1;
    res.nx = nx[15:0];
    res.ny = ny[15:0];
    res.depth = (dep > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : dep[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    n_errors++;
  endtask

  // Drop valid only when an idle gap follows.
  task automatic random_gap(bit allow);
    int g;
    if (!allow) return;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g == 0) return;
    in_tvalid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_pair(pair_t p);
    expected_contacts.push_back(predict_contact(p));
    in_tdata <= {4'd0, p.bang, p.bhh, p.bhw, p.bcy, p.bcx,
                 p.aang, p.ahh, p.ahw, p.acy, p.acx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    random_gap(!stall_free);
  endtask

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    contact_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_contacts.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], 32'd0);
      end else begin
        exp = expected_contacts.pop_front();
        if (out_tdata[0] !== exp.hit) report_mismatch("hit", out_tdata[0], exp.hit);
        if (out_tdata[16:1] !== exp.nx) report_mismatch("normal_x", out_tdata[16:1], exp.nx);
        if (out_tdata[32:17] !== exp.ny) report_mismatch("normal_y", out_tdata[32:17], exp.ny);
        if (out_tdata[64:33] !== exp.depth) report_mismatch("depth", out_tdata[64:33], exp.depth);
        if (out_tdata[71:65] !== 7'd0) report_mismatch("pad", out_tdata[71:65], 0);
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (stall_free) out_tready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) out_tready <= 1'b1;
  end

  function automatic pair_t random_pair(int mode);
    pair_t p;
    logic [31:0] span;
    span = (mode == 0) ? 32'h0004_0000 : 32'h0100_0000;
    p.acx = $urandom_range(0, span) - span / 2;
    p.acy = $urandom_range(0, span) - span / 2;
    p.bcx = p.acx + $urandom_range(0, span) - span / 2;
    p.bcy = p.acy + $urandom_range(0, span) - span / 2;
    p.ahw = 31'($urandom_range(0, span)); p.ahh = 31'($urandom_range(0, span));
    p.bhw = 31'($urandom_range(0, span)); p.bhh = 31'($urandom_range(0, span));
    p.aang = 16'($urandom); p.bang = 16'($urandom);
    if (mode == 2) begin
      p.acx = $urandom; p.acy = $urandom; p.bcx = $urandom; p.bcy = $urandom;
      p.ahw = 31'($urandom); p.ahh = 31'($urandom);
      p.bhw = 31'($urandom); p.bhh = 31'($urandom);
    end
    if ($urandom_range(0, 7) == 0) p.aang = {2'($urandom_range(0, 3)), 14'd0};
    if ($urandom_range(0, 7) == 0) p.bang = {2'($urandom_range(0, 3)), 14'd0};
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    // Axis-aligned unit squares, overlapping, touching, apart.
    p = '{32'd0, 32'd0, 31'h10000, 31'h10000, 16'd0,
          32'h8000, 32'd0, 31'h10000, 31'h10000, 16'd0};
    send_pair(p);
    p.bcx = 32'h20000; send_pair(p);
    p.bcx = 32'h20001; send_pair(p);
    p.bcx = -32'sh8000; send_pair(p);
    // Coincident centers keep the axis unflipped.
    p.bcx = 32'd0; send_pair(p);
    // Points and segments.
    p = '{32'd0, 32'd0, 31'd0, 31'd0, 16'h2000, 32'd0, 32'd0, 31'd0, 31'd0, 16'h6000};
    send_pair(p);
    p.ahw = 31'h10000; p.bhh = 31'h10000; send_pair(p);
    // Quarter turns and rotated boxes.
    for (int q = 0; q < 4; q++) begin
      p = '{32'd0, 32'd0, 31'h30000, 31'h10000, 16'(q * 16384),
            32'h8000, 32'h4000, 31'h10000, 31'h20000, 16'(q * 16384 + 8192)};
      send_pair(p);
    end
    p.aang = 16'hFFFF; p.bang = 16'h3FFF; send_pair(p);
    // Extremes: saturating depth, edges of the coordinate range.
    p = '{32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h1234};
    send_pair(p);
    p.acx = 32'h7FFF_FFFF; p.acy = 32'h7FFF_FFFF; send_pair(p);
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 31'd0, 16'hFFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'd0, 16'h8000};
    send_pair(p);
    p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd0, 16'hC000,
          32'h0, 32'h0, 31'd0, 31'h7FFF_FFFF, 16'h4000};
    send_pair(p);
  endtask

  task automatic test_random_overlap();
    for (int i = 0; i < 700; i++) send_pair(random_pair($urandom_range(0, 3) == 0));
  endtask

  task automatic test_random_wide();
    for (int i = 0; i < 300; i++) send_pair(random_pair($urandom_range(1, 2)));
  endtask

  task automatic test_back_to_back();
    stall_free = 1'b1;
    for (int i = 0; i < 150; i++) send_pair(random_pair(0));
    stall_free = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    n_errors = 0;
    stall_free = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_overlap();
    test_back_to_back();
    test_random_wide();
    in_tvalid <= 1'b0;
    fork
      begin
        while (expected_contacts.size() != 0) @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
        n_errors++;
      end
    join_any
    disable fork;
    if (n_errors == 0) $display("obb_separating_axis_collision verification clean");
    else $display("obb_separating_axis_collision verification failed");
    $finish;
  end

endmodule
